// ===== rtl/sast_pkg.sv =====
// sast_pkg: shared types and codes for the sorted address set table.
// Holds request/response payload structs, cell control structs and op/status codes.
// No dependencies.
package sast_pkg;

	localparam int ADDR_W  = 32;
	localparam int RANK_W  = 8;
	localparam int CNT_W   = 9;
	localparam int OP_W    = 3;
	localparam int ST_W    = 3;
	localparam int MAX_DEPTH = 256;

	localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
	localparam logic [OP_W-1:0] OP_FIND     = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
	localparam logic [OP_W-1:0] OP_READ     = 3'd3;
	localparam logic [OP_W-1:0] OP_REM_RANK = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
	localparam logic [ST_W-1:0] ST_MISSING  = 3'd2;
	localparam logic [ST_W-1:0] ST_BAD_RANK = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [ADDR_W-1:0] address;
		logic [RANK_W-1:0] rank;
	} request_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [RANK_W-1:0] found_rank;
		logic [ADDR_W-1:0] address_out;
		logic [CNT_W-1:0]  entry_count;
	} response_t;

	// compare phase broadcast to every cell
	typedef struct packed {
		logic              en;
		logic              by_rank;
		logic [ADDR_W-1:0] key;
		logic [RANK_W-1:0] rank;
		logic [CNT_W-1:0]  count;
	} sast_cmp_t;

	// shift phase broadcast to every cell
	typedef struct packed {
		logic              en;
		logic              ins;
		logic              rem;
		logic [ADDR_W-1:0] key;
	} sast_shift_t;

endpackage

// ===== rtl/sast_cell.sv =====
// sast_cell: one slot of the sorted row; compares against the broadcast key or rank
// and shifts left or right with its neighbors. Depends on sast_pkg.
module sast_cell
	import sast_pkg::*;
#(
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  sast_cmp_t         cmp,
	input  sast_shift_t       shf,
	input  logic [ADDR_W-1:0] left_entry,
	input  logic              left_ge,
	input  logic [ADDR_W-1:0] right_entry,
	output logic [ADDR_W-1:0] entry,
	output logic              ge,
	output logic              eq,
	output logic              boundary
);

	logic [ADDR_W-1:0] entry_q;
	logic              ge_q;
	logic              eq_q;
	logic              valid;
	logic              ge_d;

	assign valid = CNT_W'(INDEX) < cmp.count;
	assign ge_d  = cmp.by_rank ? (RANK_W'(INDEX) >= cmp.rank)
	                           : !(valid && (entry_q < cmp.key));

	always_ff @(posedge clk) begin
		if (cmp.en) begin
			ge_q <= ge_d;
			eq_q <= valid && (entry_q == cmp.key);
		end
		if (shf.en && ge_q) begin
			if (shf.ins) begin
				entry_q <= left_ge ? left_entry : shf.key;
			end else if (shf.rem) begin
				entry_q <= right_entry;
			end
		end
	end

	assign entry    = entry_q;
	assign ge       = ge_q;
	assign eq       = eq_q;
	assign boundary = ge_q && !left_ge;

endmodule

// ===== rtl/sorted_address_set_table.sv =====
// sorted_address_set_table: top level; request sequencer, result logic and
// the row of sast_cell slots. Depends on sast_pkg and sast_cell.
//
// Usage:
//   A request transfer happens at a rising edge with start high and busy low.
//   request carries operation, address and rank; the block keeps up to
//   min(CAPACITY, 256) unique addresses in ascending order.
//   Each request has a compare phase, in which every cell compares its
//   entry with the key (or its index with the rank), then a shift phase in which
//   the result is formed from the cell flags and the row shifts in place.
//   busy is high only during the compare phase, so a new request may be
//   accepted while the previous one is in its shift phase.
//   The response is on response for exactly one cycle with done high, the
//   cycle after the shift; it is registered, so the next request may already
//   be in its compare cycle. The receiver cannot stall the block.
//   Reset clears the entry count and the sequencer; entry contents are not
//   cleared and are never read above the count.
module sorted_address_set_table
	import sast_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  request_t  request,
	output logic      done,
	output response_t response
);

	localparam int DEPTH = (CAPACITY < MAX_DEPTH) ? CAPACITY : MAX_DEPTH;

	typedef enum logic [1:0] {S_IDLE, S_CMP, S_APPLY} state_t;

	state_t      state_q;
	logic        done_q;
	response_t   response_q;
	logic [CNT_W-1:0] count_q;
	request_t    req_q;

	sast_cmp_t   cmp;
	sast_shift_t shf;
	response_t   resp_d;
	logic [CNT_W-1:0] count_d;

	logic [ADDR_W-1:0] entry [DEPTH];
	logic [DEPTH-1:0]  ge;
	logic [DEPTH-1:0]  eq;
	logic [DEPTH-1:0]  bnd;

	logic              accept;
	logic              hit;
	logic [RANK_W-1:0] pos;
	logic [ADDR_W-1:0] rd_addr;
	logic              by_rank;
	logic              rank_ok;
	logic              full;

	assign busy   = (state_q == S_CMP);
	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
	end

	assign by_rank = (req_q.operation == OP_READ) || (req_q.operation == OP_REM_RANK);
	assign rank_ok = {1'b0, req_q.rank} < count_q;
	assign full    = count_q >= CNT_W'(DEPTH);

	assign cmp.en      = (state_q == S_CMP);
	assign cmp.by_rank = by_rank;
	assign cmp.key     = req_q.address;
	assign cmp.rank    = req_q.rank;
	assign cmp.count   = count_q;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [ADDR_W-1:0] l_entry;
			logic              l_ge;
			logic [ADDR_W-1:0] r_entry;
			if (gi == 0) begin : g_first
				assign l_entry = '0;
				assign l_ge    = 1'b0;
			end else begin : g_mid
				assign l_entry = entry[gi-1];
				assign l_ge    = ge[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign r_entry = entry[gi];
			end else begin : g_inner
				assign r_entry = entry[gi+1];
			end
			sast_cell #(.INDEX(gi)) u_cell (
				.clk         (clk),
				.cmp         (cmp),
				.shf         (shf),
				.left_entry  (l_entry),
				.left_ge     (l_ge),
				.right_entry (r_entry),
				.entry       (entry[gi]),
				.ge          (ge[gi]),
				.eq          (eq[gi]),
				.boundary    (bnd[gi])
			);
		end
	endgenerate

	// boundary is one-hot or empty; reduce it to an index and the selected entry
	always_comb begin
		hit     = 1'b0;
		pos     = '0;
		rd_addr = '0;
		for (int i = 0; i < DEPTH; i++) begin
			hit     = hit | (bnd[i] & eq[i]);
			pos     = pos | (bnd[i] ? RANK_W'(i) : '0);
			rd_addr = rd_addr | (bnd[i] ? entry[i] : '0);
		end
	end

	always_comb begin
		resp_d  = '{status: ST_OK, found_rank: '0, address_out: '0, entry_count: count_q};
		shf.en  = (state_q == S_APPLY);
		shf.ins = 1'b0;
		shf.rem = 1'b0;
		shf.key = req_q.address;
		case (req_q.operation) inside
			OP_INSERT: begin
				if (hit) begin
					resp_d.status     = ST_DUP;
					resp_d.found_rank = pos;
				end else if (full) begin
					resp_d.status = ST_FULL;
				end else begin
					resp_d.found_rank  = pos;
					resp_d.entry_count = count_q + 1'b1;
					shf.ins            = 1'b1;
				end
			end
			OP_FIND, OP_REMOVE: begin
				if (!hit) begin
					resp_d.status = ST_MISSING;
				end else begin
					resp_d.found_rank = pos;
					if (req_q.operation == OP_REMOVE) begin
						resp_d.address_out = req_q.address;
						resp_d.entry_count = count_q - 1'b1;
						shf.rem            = 1'b1;
					end
				end
			end
			OP_READ, OP_REM_RANK: begin
				if (!rank_ok) begin
					resp_d.status = ST_BAD_RANK;
				end else begin
					resp_d.found_rank  = req_q.rank;
					resp_d.address_out = rd_addr;
					if (req_q.operation == OP_REM_RANK) begin
						resp_d.entry_count = count_q - 1'b1;
						shf.rem            = 1'b1;
					end
				end
			end
			OP_CLEAR: begin
				resp_d.entry_count = '0;
			end
			default: begin
			end
		endcase
		count_d = resp_d.entry_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			done_q     <= 1'b0;
			count_q    <= '0;
			response_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					done_q     <= 1'b1;
					response_q <= resp_d;
					count_q    <= count_d;
					state_q    <= start ? S_CMP : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign response = response_q;

	a_done_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_APPLY))
		else $error("done without a shift cycle");

	a_cmp_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |=> state_q == S_APPLY)
		else $error("compare phase not followed by shift");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		done && response.status == ST_OK && $past(req_q.operation == OP_INSERT)
		|-> response.entry_count == $past(count_q) + 1'b1)
		else $error("insert did not grow the count by one");

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> response.entry_count == count_q)
		else $error("reported count differs from stored count");

endmodule
